FILE: src/fraction_arith_reduce_top_defines.svh
// Assertion macros shared by the fraction arithmetic block.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef FRACTION_ARITH_REDUCE_TOP_DEFINES_SVH
`define FRACTION_ARITH_REDUCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FRAC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fraction_arith_reduce: assertion failed");

// Next-cycle implication
`define FRAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fraction_arith_reduce: assertion failed");

`else

`define FRAC_ASSERT_IMPL(label, ante, cons)
`define FRAC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/frac_pkg.sv
// Shared types and constants for the fraction arithmetic block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package frac_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RAW_WIDTH_DEF     = 2 * OPERAND_WIDTH_DEF + 1;
  localparam int RES_WIDTH         = 32;
  localparam int OP_WIDTH          = 2;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MUL_T1,
    MUL_T2,
    MUL_RD
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_GCD,
    DIV_NUM,
    DIV_DEN
  } div_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T1,
    ST_MUL_T2,
    ST_MUL_RD,
    ST_SUM,
    ST_GCD_CHK,
    ST_GCD_WAIT,
    ST_FIN_CHK,
    ST_QN_WAIT,
    ST_QD_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_sum;
    logic     div_start;
    div_src_t div_src;
    logic     gcd_advance;
    logic     cap_num;
    logic     cap_den;
    logic     cap_undef;
    logic     load_out;
  } frac_cmd_t;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic div_done;
    logic out_free;
  } frac_stat_t;

endpackage

`default_nettype wire

FILE: src/frac_div.sv
// Iterative signed divider with truncating quotient and remainder, one bit a cycle.
// Default width from frac_pkg; assertion macros from fraction_arith_reduce_top_defines.svh.
`default_nettype none

`include "fraction_arith_reduce_top_defines.svh"

module frac_div #(
  parameter int DATA_WIDTH = frac_pkg::RAW_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [DATA_WIDTH-1:0] dividend,
  input  wire logic signed [DATA_WIDTH-1:0] divisor,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      quotient,
  output logic signed [DATA_WIDTH-1:0]      remainder
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] dvs;
  logic                  qneg;
  logic                  rneg;

  logic [DATA_WIDTH:0]   shifted;
  logic                  ge;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] dvd_mag;
  logic [DATA_WIDTH-1:0] dvs_mag;

  // Magnitudes of the operands
  assign dvd_mag = dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-dividend) : DATA_WIDTH'(dividend);
  assign dvs_mag = divisor[DATA_WIDTH-1]  ? DATA_WIDTH'(-divisor)  : DATA_WIDTH'(divisor);

  // One restoring step
  assign shifted = {rem, quo[DATA_WIDTH-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  // Control: busy flag, bit counter, completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dvd_mag;
      dvs  <= dvs_mag;
      qneg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      rneg <= dividend[DATA_WIDTH-1];
    end else if (busy) begin
      rem <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo <= {quo[DATA_WIDTH-2:0], ge};
    end
  end

  // Apply signs: quotient by the operand signs, remainder by the dividend
  assign quotient  = qneg ? -$signed(quo) : $signed(quo);
  assign remainder = rneg ? -$signed(rem) : $signed(rem);

  `FRAC_ASSERT_IMPL(a_start_when_free, start, !busy)
  `FRAC_ASSERT_IMPL(a_rem_below_divisor, done, rem < dvs)
  `FRAC_ASSERT_NEXT(a_done_single, done, !done)

endmodule

`default_nettype wire

FILE: src/frac_dp.sv
// Datapath: operand registers, shared multiplier, cross-product sum, gcd
// registers, divider and output register. Uses frac_pkg and frac_div.
`default_nettype none

module frac_dp #(
  parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire frac_pkg::frac_cmd_t             cmd,
  output frac_pkg::frac_stat_t                 stat,
  input  wire logic [frac_pkg::OP_WIDTH-1:0]   operation,
  input  wire logic signed [OPERAND_WIDTH-1:0] num_a,
  input  wire logic signed [OPERAND_WIDTH-1:0] den_a,
  input  wire logic signed [OPERAND_WIDTH-1:0] num_b,
  input  wire logic signed [OPERAND_WIDTH-1:0] den_b,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [frac_pkg::RES_WIDTH-1:0] res_num,
  output logic signed [frac_pkg::RES_WIDTH-1:0] res_den,
  output logic                                 undefined_flag
);

  import frac_pkg::*;

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int RW = PW + 1;

  op_t                         op;
  logic signed [OPERAND_WIDTH-1:0] na, da, nb, db;
  logic signed [PW-1:0]        t1, t2;
  logic signed [RW-1:0]        rn, rd, x, y;
  logic signed [RES_WIDTH-1:0] qn, qd;
  logic                        undef;

  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PW-1:0]        prod;
  logic signed [RW-1:0]        sum;
  logic signed [RW-1:0]        div_dvd, div_dvs;
  logic signed [RW-1:0]        div_q, div_r;
  logic                        div_done;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op <= op_t'(operation);
      na <= num_a;
      da <= den_a;
      nb <= num_b;
      db <= den_b;
    end
  end

  // Pick multiplier operands for each product
  always_comb begin
    mul_a = na;
    mul_b = db;
    case (cmd.mul_sel)
      MUL_T1: begin
        mul_a = na;
        mul_b = (op == OP_MUL) ? nb : db;
      end
      MUL_T2: begin
        mul_a = nb;
        mul_b = da;
      end
      MUL_RD: begin
        mul_a = da;
        mul_b = (op == OP_DIV) ? nb : db;
      end
      default: begin
        mul_a = na;
        mul_b = db;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Combine the cross products into the raw numerator
  always_comb begin
    case (op)
      OP_ADD:  sum = RW'(t1) + RW'(t2);
      OP_SUB:  sum = RW'(t1) - RW'(t2);
      default: sum = RW'(t1);
    endcase
  end

  // Products, raw parts and the gcd pair
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_T1:  t1 <= prod;
        MUL_T2:  t2 <= prod;
        MUL_RD:  rd <= RW'(prod);
        default: t1 <= prod;
      endcase
    end
    if (cmd.load_sum) begin
      rn <= sum;
      x  <= sum;
      y  <= rd;
    end else if (cmd.gcd_advance) begin
      x <= y;
      y <= div_r;
    end
  end

  // Divider operand selection
  always_comb begin
    case (cmd.div_src)
      DIV_GCD: begin
        div_dvd = x;
        div_dvs = y;
      end
      DIV_NUM: begin
        div_dvd = rn;
        div_dvs = x;
      end
      DIV_DEN: begin
        div_dvd = rd;
        div_dvs = x;
      end
      default: begin
        div_dvd = x;
        div_dvs = y;
      end
    endcase
  end

  frac_div #(
    .DATA_WIDTH(RW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Hold the reduced parts, keeping the low result bits
  always_ff @(posedge clk) begin
    if (cmd.cap_undef) begin
      qn    <= '0;
      qd    <= '0;
      undef <= 1'b1;
    end else begin
      if (cmd.cap_num) begin
        qn    <= RES_WIDTH'(div_q);
        undef <= 1'b0;
      end
      if (cmd.cap_den) begin
        qd <= RES_WIDTH'(div_q);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_num        <= qn;
      res_den        <= qd;
      undefined_flag <= undef;
    end
  end

  // Status back to the controller
  assign stat.x_zero   = (x == '0);
  assign stat.y_zero   = (y == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

FILE: src/frac_ctrl.sv
// Controller: sequences products, Euclid iterations and the final divisions.
// Uses frac_pkg; drives the datapath through frac_cmd_t.
`default_nettype none

module frac_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire frac_pkg::frac_stat_t stat,
  output frac_pkg::frac_cmd_t       cmd
);

  import frac_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.mul_sel     = MUL_T1;
    cmd.div_src     = DIV_GCD;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL_T1;
        end
      end
      ST_MUL_T1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T1;
        state_next  = ST_MUL_T2;
      end
      ST_MUL_T2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T2;
        state_next  = ST_MUL_RD;
      end
      ST_MUL_RD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RD;
        state_next  = ST_SUM;
      end
      ST_SUM: begin
        cmd.load_sum = 1'b1;
        state_next   = ST_GCD_CHK;
      end
      ST_GCD_CHK: begin
        if (stat.y_zero) begin
          state_next = ST_FIN_CHK;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_GCD;
          state_next    = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (stat.div_done) begin
          cmd.gcd_advance = 1'b1;
          state_next      = ST_GCD_CHK;
        end
      end
      ST_FIN_CHK: begin
        if (stat.x_zero) begin
          cmd.cap_undef = 1'b1;
          state_next    = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_NUM;
          state_next    = ST_QN_WAIT;
        end
      end
      ST_QN_WAIT: begin
        cmd.div_src = DIV_DEN;
        if (stat.div_done) begin
          cmd.cap_num   = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_QD_WAIT;
        end
      end
      ST_QD_WAIT: begin
        if (stat.div_done) begin
          cmd.cap_den = 1'b1;
          state_next  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/fraction_arith_reduce_top.sv
// Signed fraction add/subtract/multiply/divide with Euclid gcd reduction.
//
// Input channel: in_valid/in_ready with operation (0 add, 1 subtract,
// 2 multiply, 3 divide) and the two fractions num_a/den_a, num_b/den_b.
// Output channel: out_valid/out_ready with res_num, res_den and
// undefined_flag (set, with both parts zero, when the raw numerator and
// denominator are both zero). Signs of the result follow the truncating gcd.
// One item at a time. Every Euclid remainder step and both final divisions
// go through one shared divider, 2 * OPERAND_WIDTH + 1 bits wide, that
// retires one quotient bit a cycle.
// The result waits in an output register: the next item is accepted while
// it is unread, and only the final hand-over stalls on the receiver.
// Reset empties the output register and returns the controller to idle.
`default_nettype none

module fraction_arith_reduce_top #(
  parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [frac_pkg::OP_WIDTH-1:0]     operation,
  input  wire logic signed [OPERAND_WIDTH-1:0]   num_a,
  input  wire logic signed [OPERAND_WIDTH-1:0]   den_a,
  input  wire logic signed [OPERAND_WIDTH-1:0]   num_b,
  input  wire logic signed [OPERAND_WIDTH-1:0]   den_b,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [frac_pkg::RES_WIDTH-1:0]  res_num,
  output logic signed [frac_pkg::RES_WIDTH-1:0]  res_den,
  output logic                                   undefined_flag
);

  import frac_pkg::*;

  frac_cmd_t  cmd;
  frac_stat_t stat;

  frac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frac_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .num_a          (num_a),
    .den_a          (den_a),
    .num_b          (num_b),
    .den_b          (den_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res_num        (res_num),
    .res_den        (res_den),
    .undefined_flag (undefined_flag)
  );

endmodule

`default_nettype wire
